/* design/vss_pkg.sv */
package vss_pkg;

  localparam int NUM_SLOTS      = 14;
  localparam int MAX_SLOT_BYTES = 10;

  localparam int SLOT_W = 4;
  localparam int LEN_W  = 4;
  localparam int BYTE_W = 8;
  localparam int VER_W  = 8;

  localparam int STORE_DEPTH = NUM_SLOTS * MAX_SLOT_BYTES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH + 16);

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic {
    REQ_UPDATE = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_type_t;

  localparam logic [LEN_W-1:0] CAP_TABLE [NUM_SLOTS] = '{
    LEN_W'(10), LEN_W'(10), LEN_W'(10), LEN_W'(10), LEN_W'(10), LEN_W'(10),
    LEN_W'(4), LEN_W'(4), LEN_W'(4), LEN_W'(4),
    LEN_W'(4), LEN_W'(6), LEN_W'(6), LEN_W'(8)
  };

  // byte capacity of a slot, limited to the per-slot store size
  function automatic logic [LEN_W-1:0] slot_capacity(input logic [SLOT_W-1:0] slot);
    logic [LEN_W-1:0] cap;
    cap = LEN_W'(MAX_SLOT_BYTES);
    if (int'(slot) < NUM_SLOTS) begin
      if (int'(CAP_TABLE[slot]) < MAX_SLOT_BYTES) begin
        cap = CAP_TABLE[slot];
      end
    end
    return cap;
  endfunction

endpackage

/* design/vss_ram.sv */
module vss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* design/versioned_status_slot_store_top.sv */
// the last input byte is registered in the compare stage, its result word in the output register
// throughput: one input word per cycle unless stalled, set by the single compare-and-write stage
//   fed from the byte store read, with a one-entry bypass for back-to-back addresses
// a full output register stalls the compare stage, which then holds in_tready low
// reset (rst_n low, synchronous) zeroes all lengths, versions, position and flags;
//   the byte store is not cleared
module versioned_status_slot_store_top
  import vss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // slot_index[3:0], update_length[7:4], data_byte[15:8]
  input  logic                  in_tuser,   // req_type
  input  logic                  in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // result_slot[3:0], new_version[11:4], stored_length[15:12]
  output logic                  out_tuser   // length_error
);

  logic              in_accept;
  logic [SLOT_W-1:0] in_slot;
  logic [LEN_W-1:0]  in_len;
  logic [BYTE_W-1:0] in_byte;
  logic [ADDR_W-1:0] rd_addr;

  logic [LEN_W-1:0] pos_r, pos_nxt;

  logic              s1_valid_r;
  req_type_t         s1_req_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_last_r;
  logic [LEN_W-1:0]  s1_pos_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              byp_valid_r, byp_valid_nxt;
  logic [BYTE_W-1:0] byp_data_r;

  logic [LEN_W-1:0] len_r [NUM_SLOTS];
  logic [VER_W-1:0] ver_r [NUM_SLOTS];
  logic             cd_r;

  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r;
  logic [VER_W-1:0]  out_ver_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_err_r;

  logic              s1_go;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] old_byte;
  logic              s1_in_range;
  logic [LEN_W-1:0]  s1_cap;
  logic              s1_err;
  logic [LEN_W-1:0]  old_len;
  logic [VER_W-1:0]  old_ver;
  logic              wr_cond;
  logic              wr_en;
  logic              cd_acc;
  logic              changed;
  logic              s1_result;

  assign in_slot = in_tdata[SLOT_W-1:0];
  assign in_len  = in_tdata[SLOT_W +: LEN_W];
  assign in_byte = in_tdata[SLOT_W+LEN_W +: BYTE_W];

  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_accept = in_tvalid && in_tready;

  assign rd_addr = ADDR_W'(in_slot) * ADDR_W'(MAX_SLOT_BYTES) + ADDR_W'(pos_r);

  // byte position is shared by all slots and tracked at the input side
  always_comb begin
    pos_nxt = pos_r;
    if (in_accept) begin
      if (req_type_t'(in_tuser) == REQ_CLEAR || in_tlast) begin
        pos_nxt = '0;
      end else if (int'(in_slot) < NUM_SLOTS && pos_r != '1) begin
        pos_nxt = pos_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  vss_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 ** ADDR_W)
  ) u_bytes (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (s1_data_r),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // a write landing on the same edge as the read is forwarded
  assign byp_valid_nxt = wr_en && (s1_addr_r == rd_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r    <= req_type_t'(in_tuser);
      s1_slot_r   <= in_slot;
      s1_len_r    <= in_len;
      s1_data_r   <= in_byte;
      s1_last_r   <= in_tlast;
      s1_pos_r    <= pos_r;
      s1_addr_r   <= rd_addr;
      byp_valid_r <= byp_valid_nxt;
      byp_data_r  <= s1_data_r;
    end
  end

  assign old_byte    = byp_valid_r ? byp_data_r : ram_rdata;
  assign s1_in_range = int'(s1_slot_r) < NUM_SLOTS;
  assign s1_cap      = slot_capacity(s1_slot_r);
  assign s1_err      = s1_len_r > s1_cap;
  assign old_len     = len_r[s1_slot_r];
  assign old_ver     = ver_r[s1_slot_r];

  assign wr_cond = (s1_req_r == REQ_UPDATE) && s1_in_range && !s1_err && (s1_pos_r < s1_len_r);
  assign wr_en   = s1_go && wr_cond;
  // bytes only count as changed when the length matches the stored one
  assign cd_acc  = cd_r || (wr_cond && (s1_len_r == old_len) && (old_byte != s1_data_r));
  assign changed = cd_acc || (s1_len_r != old_len);

  assign s1_result = (s1_req_r == REQ_UPDATE) && s1_in_range && s1_last_r && (s1_err || changed);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        len_r[i] <= '0;
        ver_r[i] <= '0;
      end
    end else if (s1_go) begin
      if (s1_req_r == REQ_CLEAR) begin
        cd_r <= 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          len_r[i] <= '0;
          ver_r[i] <= '0;
        end
      end else if (s1_last_r) begin
        cd_r <= 1'b0;
        if (s1_in_range && !s1_err) begin
          len_r[s1_slot_r] <= s1_len_r;
          if (changed) begin
            ver_r[s1_slot_r] <= old_ver + VER_W'(1);
          end
        end
      end else if (s1_in_range) begin
        cd_r <= cd_acc;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_go && s1_result) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_result) begin
      out_slot_r <= s1_slot_r;
      out_err_r  <= s1_err;
      if (s1_err) begin
        out_ver_r <= old_ver;
        out_len_r <= old_len;
      end else begin
        out_ver_r <= old_ver + VER_W'(1);
        out_len_r <= s1_len_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_ver_r, out_slot_r};
  assign out_tuser  = out_err_r;

endmodule

/* design/vss_checker.sv */
module vss_checker
  import vss_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // reset leaves no result pending and the input open
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

  // reported slot exists
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> int'(out_tdata[3:0]) < NUM_SLOTS)
    else $error("result slot out of range");

  // stored length never exceeds the slot capacity, also on error words
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:12] <= slot_capacity(out_tdata[3:0]))
    else $error("stored length above capacity");

  // the input only stalls while a result word is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

endmodule

bind versioned_status_slot_store_top vss_checker u_vss_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import vss_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_WORDS  = 650;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_TAIL  = 60;
  localparam int SLOT_CAP [NUM_SLOTS] = '{10, 10, 10, 10, 10, 10, 4, 4, 4, 4, 4, 6, 6, 8};

  typedef struct packed {
    req_type_t          req;
    logic [SLOT_W-1:0]  slot;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  data;
    logic               last;
  } slot_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [VER_W-1:0]  ver;
    logic [LEN_W-1:0]  len;
    logic              err;
  } slot_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  versioned_status_slot_store_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  slot_word_t   word_q[$];
  slot_report_t version_reports_q[$];
  int           n_total = 0;
  int           n_accepted = 0;
  int           fail_cnt = 0;
  int           cycle_cnt = 0;
  int           hold_cnt = 0;

  // predicted block state
  logic [BYTE_W-1:0] st_bytes [NUM_SLOTS][MAX_SLOT_BYTES];
  logic [LEN_W-1:0]  st_len [NUM_SLOTS];
  logic [VER_W-1:0]  st_ver [NUM_SLOTS];
  logic [LEN_W-1:0]  st_pos;
  logic              st_diff;

  // stimulus-side tracking of what has been written, to steer clear of unwritten compares
  int                gen_len [NUM_SLOTS];
  int                gen_pos;
  bit                gen_wr [NUM_SLOTS][MAX_SLOT_BYTES];
  logic [BYTE_W-1:0] gen_byte [NUM_SLOTS][MAX_SLOT_BYTES];
  int                n_counted;

  function automatic void store_update(input slot_word_t w);
    logic         err;
    logic         changed;
    slot_report_t r;
    if (w.req == REQ_CLEAR) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st_len[i] = '0;
        st_ver[i] = '0;
      end
      st_pos  = '0;
      st_diff = 1'b0;
      return;
    end
    if (w.slot >= NUM_SLOTS) begin
      if (w.last) begin
        st_pos  = '0;
        st_diff = 1'b0;
      end
      return;
    end
    err = int'(w.len) > SLOT_CAP[w.slot];
    if (!err && st_pos < w.len) begin
      if (w.len == st_len[w.slot] && st_bytes[w.slot][st_pos] != w.data) st_diff = 1'b1;
      st_bytes[w.slot][st_pos] = w.data;
    end
    if (st_pos != 4'hF) st_pos = st_pos + 1'b1;
    if (!w.last) return;
    if (err) begin
      r = '{w.slot, st_ver[w.slot], st_len[w.slot], 1'b1};
      version_reports_q.push_back(r);
    end else begin
      changed = st_diff || (w.len != st_len[w.slot]);
      st_len[w.slot] = w.len;
      if (changed) begin
        st_ver[w.slot] = st_ver[w.slot] + 1'b1;
        r = '{w.slot, st_ver[w.slot], w.len, 1'b0};
        version_reports_q.push_back(r);
      end
    end
    st_pos  = '0;
    st_diff = 1'b0;
  endfunction

  function automatic void queue_word(input req_type_t req, input int slot, input int len,
                                     input int data, input bit last);
    slot_word_t w;
    if (req == REQ_CLEAR) begin
      for (int i = 0; i < NUM_SLOTS; i++) gen_len[i] = 0;
      gen_pos = 0;
      n_counted++;
    end else if (slot < NUM_SLOTS) begin
      // a compare against a never-written byte: shift the length so no compare happens
      if (len <= SLOT_CAP[slot] && gen_pos < len && len == gen_len[slot] &&
          !gen_wr[slot][gen_pos]) len = len - 1;
      if (len <= SLOT_CAP[slot] && gen_pos < len) begin
        gen_wr[slot][gen_pos]   = 1'b1;
        gen_byte[slot][gen_pos] = data[7:0];
      end
      if (last) begin
        if (len <= SLOT_CAP[slot]) gen_len[slot] = len;
        gen_pos = 0;
      end else if (gen_pos < 15) begin
        gen_pos++;
      end
      n_counted++;
    end else if (last) begin
      gen_pos = 0;
    end
    w.req  = req;
    w.slot = SLOT_W'(slot);
    w.len  = LEN_W'(len);
    w.data = BYTE_W'(data);
    w.last = last;
    word_q.push_back(w);
  endfunction

  function automatic bit content_known(input int slot, input int len);
    for (int p = 0; p < len; p++) if (!gen_wr[slot][p]) return 1'b0;
    return 1'b1;
  endfunction

  // mode 0: random bytes, 1: repeat stored content, 2: stored content with one bit flipped
  function automatic void queue_update(input int slot, input int len, input int nbytes,
                                       input int mode);
    int                flip;
    logic [BYTE_W-1:0] b;
    flip = $urandom_range(0, (len > 0) ? len - 1 : 0);
    for (int p = 0; p < nbytes; p++) begin
      b = BYTE_W'($urandom);
      if (mode != 0 && p < len) begin
        b = gen_byte[slot][p];
        if (mode == 2 && p == flip) b = b ^ (8'h01 << $urandom_range(0, 7));
      end
      queue_word(REQ_UPDATE, slot, len, int'(b), p == nbytes - 1);
    end
  endfunction

  // sender
  int tx_gap = 0;
  int tx_idle_pct = 20;
  slot_word_t drv_word;

  always @(posedge clk) begin
    logic nxt_vld;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st_len[i] = '0;
        st_ver[i] = '0;
        for (int j = 0; j < MAX_SLOT_BYTES; j++) st_bytes[i][j] = '0;
      end
      st_pos  = '0;
      st_diff = 1'b0;
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        store_update(drv_word);
        n_accepted <= n_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        nxt_vld = 1'b0;
        if ($urandom_range(0, 63) == 0) tx_idle_pct = 20 * $urandom_range(0, 2);
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (word_q.size() != 0) begin
          // keep offering while the receiver is held off so the block backs up
          if (word_q.size() > QUIET_TAIL && hold_cnt == 0 &&
              $urandom_range(0, 99) < tx_idle_pct) begin
            tx_gap = $urandom_range(0, 13);
          end else begin
            drv_word = word_q.pop_front();
            nxt_vld  = 1'b1;
          end
        end
        in_tvalid <= nxt_vld;
        if (nxt_vld) begin
          in_tdata <= {drv_word.data, drv_word.len, drv_word.slot};
          in_tuser <= drv_word.req;
          in_tlast <= drv_word.last;
        end
      end
    end
  end

  // receiver and checker
  int rx_gap = 0;
  int rx_idle_pct = 20;
  bit hold_done = 1'b0;

  task automatic report_mismatch(input string why, input slot_report_t want,
                                 input slot_report_t got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display({"mismatch (%s): expected slot=%0d ver=%0d len=%0d err=%0d, ",
                "got slot=%0d ver=%0d len=%0d err=%0d"},
               why, want.slot, want.ver, want.len, want.err, got.slot, got.ver, got.len, got.err);
  endtask

  always @(posedge clk) begin
    slot_report_t got;
    slot_report_t want;
    logic         nxt_rdy;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[3:0], out_tdata[11:4], out_tdata[15:12], out_tuser};
        if (version_reports_q.size() == 0) begin
          report_mismatch("unexpected word", '0, got);
        end else begin
          want = version_reports_q.pop_front();
          if (got.slot !== want.slot || got.ver !== want.ver || got.len !== want.len ||
              got.err !== want.err)
            report_mismatch("field", want, got);
        end
      end
      if ($urandom_range(0, 63) == 0) rx_idle_pct = 20 * $urandom_range(0, 2);
      nxt_rdy = 1'b1;
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        nxt_rdy = 1'b0;
      end else if (!hold_done && n_accepted >= 150) begin
        hold_done = 1'b1;
        hold_cnt <= HOLD_CYCLES;
        nxt_rdy = 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        nxt_rdy = 1'b0;
      end else if (n_accepted < n_total - QUIET_TAIL &&
                   $urandom_range(0, 99) < rx_idle_pct) begin
        rx_gap = $urandom_range(0, 13);
        nxt_rdy = 1'b0;
      end
      out_tready <= nxt_rdy;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int s;
    int len;
    int cap;
    int mode;
    int pick;
    int k;
    int rand_goal;
    bit wrap_done;

    for (int i = 0; i < NUM_SLOTS; i++) begin
      gen_len[i] = 0;
      for (int j = 0; j < MAX_SLOT_BYTES; j++) gen_wr[i][j] = 1'b0;
    end
    gen_pos   = 0;
    n_counted = 0;
    wrap_done = 1'b0;

    // directed: zero length, unchanged, errors, ignored slots, short, extra, interleave, clear
    queue_word(REQ_UPDATE, 0, 0, 8'h00, 1'b1);
    queue_update(6, 4, 4, 0);
    queue_update(6, 4, 4, 1);
    queue_word(REQ_UPDATE, 6, 5, 8'hFF, 1'b1);
    queue_word(REQ_UPDATE, 12, 15, 8'h00, 1'b1);
    queue_word(REQ_UPDATE, 14, 3, 8'hFF, 1'b0);
    queue_word(REQ_UPDATE, 15, 15, 8'h00, 1'b1);
    queue_update(13, 8, 2, 0);
    queue_update(10, 2, 4, 0);
    queue_word(REQ_UPDATE, 7, 2, 8'hFF, 1'b0);
    queue_word(REQ_UPDATE, 14, 1, 8'h00, 1'b0);
    queue_word(REQ_UPDATE, 7, 2, 8'h00, 1'b1);
    queue_word(REQ_CLEAR, 0, 0, 8'h00, 1'b0);
    queue_word(REQ_UPDATE, 0, 0, 8'hFF, 1'b1);
    queue_update(6, 4, 4, 1);

    rand_goal = n_counted + RAND_WORDS;
    while (n_counted < rand_goal) begin
      if (!wrap_done && n_counted > rand_goal - RAND_WORDS + 250) begin
        // alternate lengths on one slot until its version wraps past 255
        wrap_done = 1'b1;
        for (int i = 0; i < 260; i++)
          queue_word(REQ_UPDATE, 13, (gen_len[13] == 0) ? 1 : 0, $urandom, 1'b1);
      end
      pick = $urandom_range(0, 99);
      s    = $urandom_range(0, NUM_SLOTS - 1);
      cap  = SLOT_CAP[s];
      if (pick < 62) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(cap + 1, 15);
        else if ($urandom_range(0, 1) == 0) len = gen_len[s];
        else len = $urandom_range(0, cap);
        mode = 0;
        if (len <= cap && len == gen_len[s] && content_known(s, len))
          mode = $urandom_range(0, 2);
        queue_update(s, len, (len > 0) ? len : 1, mode);
      end else if (pick < 70) begin
        len = $urandom_range(0, cap);
        queue_update(s, len, len + $urandom_range(1, 17 - len), 0);
      end else if (pick < 78) begin
        len = $urandom_range(2, cap);
        queue_update(s, len, $urandom_range(1, len - 1), 0);
      end else if (pick < 86) begin
        len = $urandom_range(1, cap);
        k   = $urandom_range(0, len - 1);
        for (int p = 0; p < k; p++) queue_word(REQ_UPDATE, s, len, $urandom, 1'b0);
        queue_word(REQ_UPDATE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom,
                   $urandom_range(0, 3) == 0);
        for (int p = k; p < len; p++) queue_word(REQ_UPDATE, s, len, $urandom, p == len - 1);
      end else if (pick < 93) begin
        queue_word(REQ_UPDATE, $urandom_range(14, 15), $urandom_range(0, 15), $urandom,
                   1'($urandom_range(0, 1)));
      end else if (pick < 98) begin
        queue_word(REQ_UPDATE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom,
                   1'($urandom_range(0, 1)));
      end else begin
        queue_word(REQ_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15), $urandom,
                   1'($urandom_range(0, 1)));
      end
    end
    n_total = word_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_total || version_reports_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (version_reports_q.size() != 0) begin
      $display("%0d result words never arrived", version_reports_q.size());
      fail_cnt += version_reports_q.size();
    end
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
